// ===== hw/rtl/cbl_pkg.sv =====
// Package for the cascaded biquad low-pass filter.
// Holds fixed-point widths, coefficient reset values, sequencer states and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package cbl_pkg;

    localparam int STATE_BITS     = 48;
    localparam int FRAC_BITS      = 16;
    localparam int COEF_BITS      = 18;
    localparam int REG_COUNT      = 8;
    localparam int REG_IDX_BITS   = 3;
    localparam int CFG_INDEX_BITS = 4;
    localparam int LO_BITS        = STATE_BITS / 2;
    localparam int HI_BITS        = STATE_BITS - LO_BITS;
    localparam int OPND_BITS      = LO_BITS + 1;
    localparam int PROD_BITS      = COEF_BITS + OPND_BITS;
    localparam int FULL_BITS      = COEF_BITS + STATE_BITS;
    localparam int WIDE_BITS      = STATE_BITS + 2;
    localparam int GAIN_SHIFT     = 48;
    localparam int GAIN_OUT_BITS  = FULL_BITS - GAIN_SHIFT;
    localparam int CLAMP_BITS     = 32;

    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [STATE_BITS-1:0] word_t;
    typedef logic signed [WIDE_BITS-1:0]  wide_t;
    typedef logic signed [OPND_BITS-1:0]  opnd_t;

    // Unsigned Q0.32 gain of the whole cascade, held as a positive coefficient
    localparam coef_t GAIN_Q32 = 18'sd102906;

    localparam coef_t COEF_RESET [REG_COUNT] = '{
        18'sd95131, -18'sd52052, 18'sd79936, -18'sd33270,
        18'sd71228, -18'sd22507, 18'sd67263, -18'sd17606
    };

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MLO    = 12'b0000_0000_0010,
        ST_MHI    = 12'b0000_0000_0100,
        ST_PSUM   = 12'b0000_0000_1000,
        ST_ADD_P  = 12'b0000_0001_0000,
        ST_ADD_X  = 12'b0000_0010_0000,
        ST_ADD_W1A = 12'b0000_0100_0000,
        ST_ADD_W1B = 12'b0000_1000_0000,
        ST_ADD_W2 = 12'b0001_0000_0000,
        ST_GLO    = 12'b0010_0000_0000,
        ST_GHI    = 12'b0100_0000_0000,
        ST_GOUT   = 12'b1000_0000_0000
    } state_t;

    typedef struct packed {
        word_t value;
        logic  clip;
    } sat_t;

    function automatic sat_t sat_state(input wide_t v);
        sat_t r;
        r.clip = 1'b0;
        r.value = v[STATE_BITS-1:0];
        if (v[WIDE_BITS-1:STATE_BITS-1] != '0 && v[WIDE_BITS-1:STATE_BITS-1] != '1)
        begin
            r.clip = 1'b1;
            r.value = v[WIDE_BITS-1] ? {1'b1, {(STATE_BITS-1){1'b0}}}
                                     : {1'b0, {(STATE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    function automatic opnd_t lo_opnd(input word_t w);
        return signed'({1'b0, w[LO_BITS-1:0]});
    endfunction

    function automatic opnd_t hi_opnd(input word_t w);
        return OPND_BITS'(signed'(w[STATE_BITS-1:LO_BITS]));
    endfunction

endpackage

// ===== hw/rtl/cascaded_biquad_lowpass.sv =====
// Eighth-order low-pass filter: cascade of direct-form-II biquads with 1,2,1 numerator.
// Section delay words live in one synchronous memory; one shared add/saturate unit.
// Depends on cbl_pkg.
//
//  Channel | Signals                              | Dir | Beat
//  --------+--------------------------------------+-----+------------------------------
//  input   | in_valid, in_ready, sample_in        | in  | one sample
//  output  | out_valid, out_ready, sample_out,    | out | one filtered sample and flag
//          | clipped                              |     |
//  config  | cfg_wr_en, cfg_index, cfg_data       | in  | one coefficient write
//
// Each section: two partial products per multiplier, product combine, then five steps
// through the shared add/saturate unit, on delay words read on accept or at the previous
// section's last add. The output gain: low product, high product, clamp and load.
// Reset zeroes the delay words through per-entry valid bits and restores the
// coefficients; no clearing pass. A new sample is accepted only in idle, also while a
// result waits; a held result stalls the sequencer only at its final gain step.
`timescale 1ns / 1ps

module cascaded_biquad_lowpass #(
    parameter int SECTIONS    = 4,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [SAMPLE_BITS-1:0]      sample_in,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [SAMPLE_BITS-1:0]      sample_out,
    output logic                               clipped,
    input  logic                               cfg_wr_en,
    input  logic [cbl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cbl_pkg::COEF_BITS-1:0]      cfg_data
);

    import cbl_pkg::*;

    localparam int SEC_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int MEM_W = 2 * STATE_BITS;
    localparam logic signed [CLAMP_BITS-1:0] SMAX = CLAMP_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam logic signed [CLAMP_BITS-1:0] SMIN = -SMAX - 1;

    state_t state_reg, state_next;
    logic [SEC_W-1:0] sec_reg;
    logic clip_reg;
    logic out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic clipped_reg;

    coef_t coef_reg [REG_COUNT];
    coef_t fb1, fb2;
    logic [REG_IDX_BITS-1:0] fb1_idx, fb2_idx;

    logic [MEM_W-1:0] mem [SECTIONS];
    logic [MEM_W-1:0] rdata_reg;
    logic [SECTIONS-1:0] valid_reg;
    logic rvalid_reg;
    logic rd_en, mem_we;
    logic [SEC_W-1:0] rd_addr;
    word_t rd_w1, rd_w2;

    word_t w1_reg, w2_reg, x_reg, acc_reg, p1_reg, p2_reg;
    coef_t mc1, mc2;
    opnd_t md1, md2;
    logic signed [PROD_BITS-1:0] prod1, prod2;
    logic signed [PROD_BITS-1:0] pp1_lo_reg, pp1_hi_reg, pp2_lo_reg, pp2_hi_reg;
    logic signed [FULL_BITS-1:0] full1, full2;
    sat_t p1_sat, p2_sat, add_res;
    word_t add_a, add_b;

    logic signed [GAIN_OUT_BITS-1:0] gain_q;
    logic signed [CLAMP_BITS-1:0] gain_wide;
    logic signed [SAMPLE_BITS-1:0] out_val;
    logic out_clip;

    logic accept, last_sec, out_load;
    word_t x_in;

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign last_sec   = (sec_reg == SEC_W'(SECTIONS - 1));
    assign out_load   = (state_reg == ST_GOUT) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;

    assign x_in = {{(STATE_BITS - SAMPLE_BITS - FRAC_BITS){sample_in[SAMPLE_BITS-1]}},
                   sample_in, {FRAC_BITS{1'b0}}};

    // Coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end
        else if (cfg_wr_en && cfg_index < CFG_INDEX_BITS'(REG_COUNT))
        begin
            coef_reg[cfg_index[REG_IDX_BITS-1:0]] <= cfg_data;
        end
    end

    assign fb1_idx = REG_IDX_BITS'(2 * sec_reg);
    assign fb2_idx = REG_IDX_BITS'(2 * sec_reg + 1);
    assign fb1 = coef_reg[fb1_idx];
    assign fb2 = coef_reg[fb2_idx];

    // Delay word memory: {w[n-1], w[n-2]} per section
    assign mem_we  = (state_reg == ST_ADD_W1A);
    assign rd_en   = accept || ((state_reg == ST_ADD_W2) && !last_sec);
    assign rd_addr = accept ? '0 : sec_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[sec_reg] <= {acc_reg, w1_reg};
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[sec_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_w1 = rvalid_reg ? rdata_reg[MEM_W-1:STATE_BITS] : '0;
    assign rd_w2 = rvalid_reg ? rdata_reg[STATE_BITS-1:0] : '0;

    // Multiplier lanes: low half then high half of the state operand
    always_comb
    begin
        mc1 = fb1;
        mc2 = fb2;
        md1 = lo_opnd(rd_w1);
        md2 = lo_opnd(rd_w2);
        case (state_reg) inside
            ST_MHI:
            begin
                md1 = hi_opnd(w1_reg);
                md2 = hi_opnd(w2_reg);
            end
            ST_GLO:
            begin
                mc1 = GAIN_Q32;
                md1 = lo_opnd(x_reg);
            end
            ST_GHI:
            begin
                mc1 = GAIN_Q32;
                md1 = hi_opnd(x_reg);
            end
            default:
            begin
            end
        endcase
    end

    assign prod1 = mc1 * md1;
    assign prod2 = mc2 * md2;

    assign full1 = (FULL_BITS'(pp1_hi_reg) <<< LO_BITS) + FULL_BITS'(pp1_lo_reg);
    assign full2 = (FULL_BITS'(pp2_hi_reg) <<< LO_BITS) + FULL_BITS'(pp2_lo_reg);
    assign p1_sat = sat_state(signed'(full1[FULL_BITS-1:FRAC_BITS]));
    assign p2_sat = sat_state(signed'(full2[FULL_BITS-1:FRAC_BITS]));

    // Shared add/saturate unit
    always_comb
    begin
        add_a = acc_reg;
        add_b = x_reg;
        case (state_reg) inside
            ST_ADD_P:
            begin
                add_a = p1_reg;
                add_b = p2_reg;
            end
            ST_ADD_W1A, ST_ADD_W1B:
            begin
                add_b = w1_reg;
            end
            ST_ADD_W2:
            begin
                add_b = w2_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign add_res = sat_state(WIDE_BITS'(add_a) + WIDE_BITS'(add_b));

    // Output gain and clamp
    always_comb
    begin
        gain_q    = full1[FULL_BITS-1:GAIN_SHIFT];
        gain_wide = CLAMP_BITS'(gain_q);
        out_clip  = 1'b0;
        out_val   = gain_wide[SAMPLE_BITS-1:0];
        if (gain_wide > SMAX)
        begin
            out_clip = 1'b1;
            out_val  = SMAX[SAMPLE_BITS-1:0];
        end
        else if (gain_wide < SMIN)
        begin
            out_clip = 1'b1;
            out_val  = SMIN[SAMPLE_BITS-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    state_next = in_valid ? ST_MLO : ST_IDLE;
            ST_MLO:     state_next = ST_MHI;
            ST_MHI:     state_next = ST_PSUM;
            ST_PSUM:    state_next = ST_ADD_P;
            ST_ADD_P:   state_next = ST_ADD_X;
            ST_ADD_X:   state_next = ST_ADD_W1A;
            ST_ADD_W1A: state_next = ST_ADD_W1B;
            ST_ADD_W1B: state_next = ST_ADD_W2;
            ST_ADD_W2:  state_next = last_sec ? ST_GLO : ST_MLO;
            ST_GLO:     state_next = ST_GHI;
            ST_GHI:     state_next = ST_GOUT;
            ST_GOUT:    state_next = out_load ? ST_IDLE : ST_GOUT;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sec_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                sec_reg  <= '0;
                clip_reg <= 1'b0;
            end
            else
            begin
                if (state_reg == ST_ADD_W2 && !last_sec)
                begin
                    sec_reg <= sec_reg + 1'b1;
                end
                case (state_reg) inside
                    ST_PSUM:
                    begin
                        clip_reg <= clip_reg | p1_sat.clip | p2_sat.clip;
                    end
                    ST_ADD_P, ST_ADD_X, ST_ADD_W1A, ST_ADD_W1B, ST_ADD_W2:
                    begin
                        clip_reg <= clip_reg | add_res.clip;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg <= x_in;
        end
        case (state_reg) inside
            ST_MLO:
            begin
                w1_reg     <= rd_w1;
                w2_reg     <= rd_w2;
                pp1_lo_reg <= prod1;
                pp2_lo_reg <= prod2;
            end
            ST_GLO:
            begin
                pp1_lo_reg <= prod1;
            end
            ST_MHI:
            begin
                pp1_hi_reg <= prod1;
                pp2_hi_reg <= prod2;
            end
            ST_GHI:
            begin
                pp1_hi_reg <= prod1;
            end
            ST_PSUM:
            begin
                p1_reg <= p1_sat.value;
                p2_reg <= p2_sat.value;
            end
            ST_ADD_P, ST_ADD_X, ST_ADD_W1A, ST_ADD_W1B:
            begin
                acc_reg <= add_res.value;
            end
            ST_ADD_W2:
            begin
                acc_reg <= add_res.value;
                x_reg   <= add_res.value;
            end
            default:
            begin
            end
        endcase
        if (out_load)
        begin
            sample_out_reg <= out_val;
            clipped_reg    <= clip_reg | out_clip;
        end
    end

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && rd_en) |-> (rd_addr != sec_reg))
        else $error("delay memory read and write hit the same section");

    a_sec_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        sec_reg <= SEC_W'(SECTIONS - 1))
        else $error("section counter out of range");

    a_result_from_gain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_GOUT))
        else $error("result loaded outside the gain step");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GOUT && out_valid_reg && !out_ready) |=> (state_reg == ST_GOUT))
        else $error("sequencer left the gain step while the result was held");

    a_accept_clears_section: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (sec_reg == '0 && state_reg == ST_MLO))
        else $error("sample accepted without restarting at the first section");

endmodule
